@@ design/icfsc_pkg.sv @@
// ----------------------------------------------------------------------------
// icfsc_pkg
// Shared types and constants for the per-source flood counter: request and
// result payloads, table entry layout and per-cell control.
// ----------------------------------------------------------------------------
package icfsc_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned CNT_W       = 32;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(1000);

  localparam logic       CMD_COUNT = 1'b0;
  localparam logic       CMD_SWEEP = 1'b1;

  localparam logic [1:0] KIND_COUNTED = 2'd0;
  localparam logic [1:0] KIND_DROPPED = 2'd1;
  localparam logic [1:0] KIND_ALERT   = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  typedef struct packed {
    logic             cmd;
    logic [MAC_W-1:0] src_mac;
    logic [IP_W-1:0]  src_ip;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [MAC_W-1:0] alert_mac;
    logic [IP_W-1:0]  alert_ip;
    logic [CNT_W-1:0] pkt_count;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } key_t;

  typedef struct packed {
    logic             valid;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CMP,
    OP_UPD,
    OP_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     any_match;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_SWEEP
  } state_e;

endpackage

@@ design/icfsc_cell.sv @@
// ----------------------------------------------------------------------------
// icfsc_cell
// One table entry: key compare, saturating count update, claim when it is
// the first free entry, and shift towards cell 0 during a sweep.
// ----------------------------------------------------------------------------
module icfsc_cell
  import icfsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  key_t             key_i,
  input  logic             prev_valid_i,
  input  entry_t           next_entry_i,
  output entry_t           entry_o,
  output logic             match_o,
  output logic [CNT_W-1:0] count_inc_o
);

  logic             valid_q, valid_d;
  logic             match_q, match_d;
  logic [MAC_W-1:0] mac_q, mac_d;
  logic [IP_W-1:0]  ip_q, ip_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             claim;

  assign count_inc_o = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);

  // entries fill from cell 0 upwards, so the first free one sits above a valid one
  assign claim = !ctrl_i.any_match && prev_valid_i && !valid_q;

  always_comb begin
    valid_d = valid_q;
    match_d = match_q;
    mac_d   = mac_q;
    ip_d    = ip_q;
    cnt_d   = cnt_q;
    case (ctrl_i.op)
      OP_CMP: begin
        match_d = valid_q && (mac_q == key_i.mac) && (ip_q == key_i.ip);
      end
      OP_UPD: begin
        match_d = 1'b0;
        if (match_q) begin
          cnt_d = count_inc_o;
        end else if (claim) begin
          valid_d = 1'b1;
          mac_d   = key_i.mac;
          ip_d    = key_i.ip;
          cnt_d   = CNT_W'(1);
        end
      end
      OP_SHIFT: begin
        match_d = 1'b0;
        valid_d = next_entry_i.valid;
        mac_d   = next_entry_i.mac;
        ip_d    = next_entry_i.ip;
        cnt_d   = next_entry_i.count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mac_q <= mac_d;
    ip_q  <= ip_d;
    cnt_q <= cnt_d;
  end

  assign entry_o = '{valid: valid_q, mac: mac_q, ip: ip_q, count: cnt_q};
  assign match_o = match_q;

endmodule

@@ design/icmp_flood_source_counter_top.sv @@
// ----------------------------------------------------------------------------
// icmp_flood_source_counter_top
// Per-source packet counter over a row of table cells with sweep alerts.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o  in_data_i  (in_t)
//   out      output     out_valid_o/out_ready_i  out_data_o (out_t)
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_data_i (flood limit)
//
// a count request runs a key compare in every cell, then the update
// a sweep shifts the row one entry a cycle into cell 0 while the result
// output is free; each entry is checked there against the limit
// reset clears all valid bits at once and sets the flood limit to 1000
// a stalled result holds the row; a new request is taken while a result waits
// ----------------------------------------------------------------------------
module icmp_flood_source_counter_top
  import icfsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] limit_q;
  key_t             key_q;
  logic             out_valid_q;
  out_t             out_q, out_d;
  logic             out_load;
  logic             out_free;
  logic             in_acc;
  cell_ctrl_t       ctrl;
  cell_op_e         op;

  entry_t           cell_entry [TABLE_DEPTH];
  logic [CNT_W-1:0] cell_inc   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] valid_vec;
  logic             any_match;
  logic [CNT_W-1:0] count_sel;
  out_t             pkt_res;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign any_match   = |match_vec;
  assign ctrl        = '{op: op, any_match: any_match};

  // row of cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic   prev_valid;
    entry_t next_entry;
    if (g == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = cell_entry[g-1].valid;
    end
    if (g == TABLE_DEPTH - 1) begin : g_end
      assign next_entry = '0;
    end else begin : g_more
      assign next_entry = cell_entry[g+1];
    end
    icfsc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key_q),
      .prev_valid_i (prev_valid),
      .next_entry_i (next_entry),
      .entry_o      (cell_entry[g]),
      .match_o      (match_vec[g]),
      .count_inc_o  (cell_inc[g])
    );
    assign valid_vec[g] = cell_entry[g].valid;
  end

  // at most one cell matches, so an and-or picks its incremented count
  always_comb begin
    count_sel = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      count_sel = count_sel | (cell_inc[i] & {CNT_W{match_vec[i]}});
    end
  end

  always_comb begin
    pkt_res = '{kind: KIND_COUNTED, alert_mac: key_q.mac, alert_ip: key_q.ip,
                pkt_count: count_sel, last: 1'b1};
    if (!any_match) begin
      if (cell_entry[TABLE_DEPTH-1].valid) begin
        pkt_res.kind      = KIND_DROPPED;
        pkt_res.pkt_count = '0;
      end else begin
        pkt_res.pkt_count = CNT_W'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.cmd == CMD_SWEEP) ? ST_SWEEP : ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          if (in_valid_i) begin
            state_d = (in_data_i.cmd == CMD_SWEEP) ? ST_SWEEP : ST_CMP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SWEEP: begin
        if (out_free && !cell_entry[0].valid) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    op         = OP_HOLD;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    out_d      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_CMP: begin
        op = OP_CMP;
      end
      ST_UPD: begin
        if (out_free) begin
          op         = OP_UPD;
          out_load   = 1'b1;
          out_d      = pkt_res;
          in_ready_o = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (out_free) begin
          if (cell_entry[0].valid) begin
            op = OP_SHIFT;
            if (cell_entry[0].count > limit_q) begin
              out_load = 1'b1;
              out_d    = '{kind: KIND_ALERT, alert_mac: cell_entry[0].mac,
                           alert_ip: cell_entry[0].ip,
                           pkt_count: cell_entry[0].count, last: 1'b0};
            end
          end else begin
            out_load   = 1'b1;
            out_d      = '0;
            out_d.kind = KIND_DONE;
            out_d.last = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= '{mac: in_data_i.src_mac, ip: in_data_i.src_ip};
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // valid entries always form a prefix of the row
  logic [TABLE_DEPTH:0] valid_ext;
  logic [TABLE_DEPTH:0] valid_inc;
  assign valid_ext = {1'b0, valid_vec};
  assign valid_inc = valid_ext + {{TABLE_DEPTH{1'b0}}, 1'b1};

  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("more than one cell matches the key");

  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(valid_inc))
    else $error("valid entries are not contiguous from cell 0");

  a_sweep_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && state_d == ST_IDLE) |=> (valid_vec == '0))
    else $error("table not empty after sweep");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && state_q == ST_SWEEP && !cell_entry[0].valid) |=>
      (out_valid_q && out_q.last && out_q.kind == KIND_DONE))
    else $error("sweep did not end with a done result");

endmodule
